### rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
	localparam int WordBits = 32;
	localparam int WideBits = 2 * WordBits;
	localparam int WideCntBits = $clog2(WideBits + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ZERO = 2'd1,
		ERR_OVFL = 2'd2
	} err_t;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [WordBits-1:0] a_num;
		logic signed [WordBits-1:0] a_den;
		logic signed [WordBits-1:0] b_num;
		logic signed [WordBits-1:0] b_den;
	} in_t;

	typedef struct packed {
		logic signed [WordBits-1:0] res_num;
		logic [WordBits-2:0] res_den;
		logic [1:0] error_code;
		logic operands_equal;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_SUM,
		ST_GINIT,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic mul4;
		logic sum;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic div_num_done;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;
endpackage

### rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
// One transaction at a time. Four 32x32 products from one shared multiplier, a
// binary gcd over 64-bit magnitudes (one step per cycle) and two 64-step
// restoring divisions. Zero denominator and division by zero skip the gcd and
// the divisions and show their result straight after the sum. The next
// transaction can be taken in the cycle after the result leaves.
module rational_arithmetic_unit import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_t out_data
);
	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	rau_dp u_dp (
		.clk(clk), .in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
	);
endmodule

### rtl/rau_ctrl.sv
// controller state machine of the rational arithmetic unit
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				cmd.mul4 = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (sts.den_zero || sts.div_zero) begin
					cmd.fin = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_GINIT;
				end
			end
			ST_GINIT: begin
				cmd.gcd_init = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIVN: begin
				if (sts.div_done) begin
					cmd.div_num_done = 1'b1;
					cmd.div_init = 1'b1;
					state_d = ST_DIVD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DIVD: begin
				if (sts.div_done) begin
					cmd.fin = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### rtl/rau_dp.sv
// datapath of the rational arithmetic unit: products, sum, binary gcd, dividers
`timescale 1ns / 1ps
module rau_dp import rau_pkg::*; (
	input logic clk,
	input in_t in_data,
	input cmd_t cmd,
	output sts_t sts,
	output out_t out_data
);
	logic [1:0] op_q;
	logic an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [WordBits-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WideBits-1:0] p_and_q, p_bnad_q, p_den_q, p_num_q;
	logic s_and_q, s_bnad_q, s_den_q, s_num_q;
	logic [WideBits-1:0] num_q, den_q;
	logic num_neg_q;
	logic [WideBits-1:0] gx_q, gy_q, gx_d, gy_d, g_diff, g_q;
	logic [WideCntBits-1:0] gk_q, gk_d;
	logic [WideBits-1:0] quo_q, rem_q, dvd_q, rn_q;
	logic [WideCntBits-1:0] cnt_q;
	logic eq_q;
	out_t out_q;

	logic [WordBits-1:0] m_x, m_y;
	logic m_sx, m_sy;
	logic [WideBits-1:0] m_p;
	logic [WideBits-1:0] rem_sh;
	logic [WideBits:0] rem_try;

	function automatic logic [WordBits-1:0] mag_of(input logic [WordBits-1:0] v);
		mag_of = v[WordBits-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		m_x = an_q; m_sx = an_neg_q; m_y = bd_q; m_sy = bd_neg_q;
		if (cmd.mul2) begin
			m_x = bn_q; m_sx = bn_neg_q; m_y = ad_q; m_sy = ad_neg_q;
		end else if (cmd.mul3) begin
			m_x = ad_q; m_sx = ad_neg_q;
			m_y = (op_q == OP_DIV) ? bn_q : bd_q;
			m_sy = (op_q == OP_DIV) ? bn_neg_q : bd_neg_q;
		end else if (cmd.mul4) begin
			m_x = an_q; m_sx = an_neg_q; m_y = bn_q; m_sy = bn_neg_q;
		end
		m_p = WideBits'(m_x) * WideBits'(m_y);
	end

	// binary gcd step: strip common twos, strip single twos, else halve the difference
	always_comb begin
		gx_d = gx_q;
		gy_d = gy_q;
		gk_d = gk_q;
		g_diff = (gx_q >= gy_q) ? (gx_q - gy_q) : (gy_q - gx_q);
		if (!gx_q[0] && !gy_q[0]) begin
			gx_d = gx_q >> 1;
			gy_d = gy_q >> 1;
			gk_d = gk_q + 1'b1;
		end else if (!gx_q[0]) begin
			gx_d = gx_q >> 1;
		end else if (!gy_q[0]) begin
			gy_d = gy_q >> 1;
		end else if (gx_q >= gy_q) begin
			gx_d = g_diff >> 1;
		end else begin
			gy_d = g_diff >> 1;
		end
	end

	assign rem_sh = {rem_q[WideBits-2:0], dvd_q[WideBits-1]};
	assign rem_try = {1'b0, rem_sh} - {1'b0, g_q};

	assign sts.den_zero = (ad_q == '0) || (bd_q == '0);
	assign sts.div_zero = (op_q == OP_DIV) && (bn_q == '0);
	assign sts.gcd_done = (gx_q == '0);
	assign sts.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data.operation;
			an_q <= mag_of(in_data.a_num); an_neg_q <= in_data.a_num[WordBits-1];
			ad_q <= mag_of(in_data.a_den); ad_neg_q <= in_data.a_den[WordBits-1];
			bn_q <= mag_of(in_data.b_num); bn_neg_q <= in_data.b_num[WordBits-1];
			bd_q <= mag_of(in_data.b_den); bd_neg_q <= in_data.b_den[WordBits-1];
		end
		if (cmd.mul1) begin
			p_and_q <= m_p; s_and_q <= (m_p != '0) && (m_sx != m_sy);
		end
		if (cmd.mul2) begin
			p_bnad_q <= m_p; s_bnad_q <= (m_p != '0) && (m_sx != m_sy);
		end
		if (cmd.mul3) begin
			p_den_q <= m_p; s_den_q <= (m_p != '0) && (m_sx != m_sy);
		end
		if (cmd.mul4) begin
			p_num_q <= m_p; s_num_q <= (m_p != '0) && (m_sx != m_sy);
		end
		if (cmd.sum) begin
			eq_q <= (p_and_q == p_bnad_q) && (s_and_q == s_bnad_q);
			den_q <= p_den_q;
			if (op_q == OP_MUL) begin
				num_q <= p_num_q;
				num_neg_q <= s_num_q != s_den_q;
			end else if (op_q == OP_DIV) begin
				num_q <= p_and_q;
				num_neg_q <= (p_and_q != '0) && (s_and_q != s_den_q);
			end else begin
				// add or subtract: an*bd +/- bn*ad over ad*bd
				if ((s_and_q == (s_bnad_q ^ (op_q == OP_SUB))) || p_bnad_q == '0
						|| p_and_q == '0) begin
					num_q <= p_and_q + p_bnad_q;
					num_neg_q <= (p_and_q != '0) ? (s_and_q != s_den_q)
						: ((s_bnad_q ^ (op_q == OP_SUB)) != s_den_q);
				end else if (p_and_q >= p_bnad_q) begin
					num_q <= p_and_q - p_bnad_q;
					num_neg_q <= s_and_q != s_den_q;
				end else begin
					num_q <= p_bnad_q - p_and_q;
					num_neg_q <= s_and_q == s_den_q;
				end
			end
		end
		if (cmd.gcd_init) begin
			gx_q <= num_q;
			gy_q <= den_q;
			gk_q <= '0;
		end else if (cmd.gcd_step) begin
			gx_q <= gx_d;
			gy_q <= gy_d;
			gk_q <= gk_d;
		end
		if (cmd.div_init) begin
			dvd_q <= cmd.div_num_done ? den_q : num_q;
			rem_q <= '0;
			cnt_q <= WideCntBits'(WideBits);
			if (cmd.div_num_done) begin
				rn_q <= quo_q;
			end else begin
				g_q <= gy_q << gk_q;
			end
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[WideBits-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (!rem_try[WideBits]) begin
				rem_q <= rem_try[WideBits-1:0];
				quo_q <= {quo_q[WideBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[WideBits-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			out_q <= '0;
			if (sts.den_zero) begin
				out_q.error_code <= ERR_ZERO;
			end else if (sts.div_zero) begin
				out_q.error_code <= ERR_ZERO;
				out_q.operands_equal <= (p_and_q == p_bnad_q) && (s_and_q == s_bnad_q);
			end else begin
				out_q.operands_equal <= eq_q;
				// here quo_q is the reduced denominator, rn_q the reduced numerator
				if ((quo_q > WideBits'({1'b0, {(WordBits-1){1'b1}}}))
						|| ((rn_q != '0) && num_neg_q
							? rn_q > WideBits'({1'b1, {(WordBits-1){1'b0}}})
							: rn_q > WideBits'({1'b0, {(WordBits-1){1'b1}}}))) begin
					out_q.error_code <= ERR_OVFL;
				end else begin
					out_q.res_num <= ((rn_q != '0) && num_neg_q)
						? WordBits'(~rn_q + 1'b1) : WordBits'(rn_q);
					out_q.res_den <= quo_q[WordBits-2:0];
				end
			end
		end
	end

	assign out_data = out_q;
endmodule

### rtl/rau_checker.sv
// port checker for the rational arithmetic unit
`timescale 1ns / 1ps
module rau_checker import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output dropped or changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result waits");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("accept not followed by busy");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ERR_NONE |->
			out_data.res_num == '0 && out_data.res_den == '0)
		else $error("error result not cleared");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/sv/rational_arithmetic_unit_tb.sv
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int RandomPerPhase = 470;

	typedef struct {
		bit neg;
		longint unsigned mag;
	} magsign_t;

	typedef struct {
		in_t d;
		out_t want;
	} trans_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	trans_t send_q[$];
	out_t fraction_q[$];
	trans_t cur;
	bit took = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int fails = 0;

	rational_arithmetic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic magsign_t split(logic signed [31:0] v);
		magsign_t r;
		longint unsigned u;
		u = {32'b0, v};
		r.neg = v[31];
		r.mag = v[31] ? ((~u + 64'd1) & 64'hFFFF_FFFF) : u;
		if (r.mag == 0) r.neg = 1'b0;
		return r;
	endfunction

	function automatic magsign_t times(magsign_t x, magsign_t y);
		magsign_t r;
		r.mag = x.mag * y.mag;
		r.neg = (r.mag != 0) && (x.neg != y.neg);
		return r;
	endfunction

	function automatic magsign_t plus(magsign_t x, magsign_t y);
		magsign_t r;
		if (x.neg == y.neg) begin
			r.mag = x.mag + y.mag;
			r.neg = x.neg;
		end else if (x.mag >= y.mag) begin
			r.mag = x.mag - y.mag;
			r.neg = x.neg;
		end else begin
			r.mag = y.mag - x.mag;
			r.neg = y.neg;
		end
		if (r.mag == 0) r.neg = 1'b0;
		return r;
	endfunction

	// reduced fraction with error code and equality flag
	function automatic void reduce_fraction(input in_t x, output out_t r);
		magsign_t an, ad, bn, bd, l, rt, num, den;
		longint unsigned p, q, t, g, rn, rd;
		bit rneg;
		r = '0;
		an = split(x.a_num);
		ad = split(x.a_den);
		bn = split(x.b_num);
		bd = split(x.b_den);
		if (ad.mag == 0 || bd.mag == 0) begin
			r.error_code = ERR_ZERO;
			return;
		end
		l = times(an, bd);
		rt = times(bn, ad);
		r.operands_equal = (l.neg == rt.neg) && (l.mag == rt.mag);
		case (op_t'(x.operation))
			OP_ADD, OP_SUB: begin
				if (op_t'(x.operation) == OP_SUB && rt.mag != 0) rt.neg = !rt.neg;
				num = plus(l, rt);
				den = times(ad, bd);
			end
			OP_MUL: begin
				num = times(an, bn);
				den = times(ad, bd);
			end
			default: begin
				if (bn.mag == 0) begin
					r.error_code = ERR_ZERO;
					return;
				end
				num = l;
				den = times(ad, bn);
			end
		endcase
		p = num.mag;
		q = den.mag;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		g = p;
		rn = num.mag / g;
		rd = den.mag / g;
		rneg = (rn != 0) && (num.neg != den.neg);
		if (rd > 64'h7FFF_FFFF || (rneg ? rn > 64'h8000_0000 : rn > 64'h7FFF_FFFF)) begin
			r.error_code = ERR_OVFL;
			return;
		end
		r.res_num = rneg ? 32'(64'd0 - rn) : 32'(rn);
		r.res_den = 31'(rd);
		r.error_code = ERR_NONE;
	endfunction

	function automatic logic [31:0] pick_word(int mode);
		int k;
		case (mode)
			0: return 32'($urandom_range(0, 200)) - 32'd100;
			1: begin
				k = $urandom_range(0, 6);
				case (k)
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h8000_0001;
					3: return 32'h0000_0001;
					4: return 32'hFFFF_FFFF;
					5: return 32'h4000_0000;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_random(int count);
		trans_t tr;
		int mode;
		int k;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 99) < 30 ? 0 : ($urandom_range(0, 99) < 25 ? 1 : 2);
			tr.d.operation = 2'($urandom_range(0, 3));
			tr.d.a_num = pick_word(mode);
			tr.d.a_den = pick_word(mode);
			tr.d.b_num = pick_word(mode);
			tr.d.b_den = pick_word(mode);
			k = $urandom_range(0, 99);
			if (k < 4) tr.d.a_den = '0;
			else if (k < 8) tr.d.b_den = '0;
			else if (k < 12) begin
				tr.d.operation = OP_DIV;
				tr.d.b_num = '0;
			end
			reduce_fraction(tr.d, tr.want);
			send_q.push_back(tr);
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (send_q.size() != 0 || in_valid || fraction_q.size() != 0);
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || took) begin
			if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur = send_q.pop_front();
				in_data <= cur.d;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		out_t got;
		out_t exp_r;
		took = in_valid && !in_stall;
		if (took) fraction_q.push_back(cur.want);
		if (out_valid && !out_stall) begin
			got = out_data;
			if (fraction_q.size() == 0) begin
				$display("%0t unexpected transaction: actual %h", $time, got);
				fails++;
			end else begin
				exp_r = fraction_q.pop_front();
				if (got.res_num !== exp_r.res_num) begin
					$display("%0t res_num: expected %0d actual %0d", $time,
						exp_r.res_num, got.res_num);
					fails++;
				end
				if (got.res_den !== exp_r.res_den) begin
					$display("%0t res_den: expected %0d actual %0d", $time,
						exp_r.res_den, got.res_den);
					fails++;
				end
				if (got.error_code !== exp_r.error_code) begin
					$display("%0t error_code: expected %0d actual %0d", $time,
						exp_r.error_code, got.error_code);
					fails++;
				end
				if (got.operands_equal !== exp_r.operands_equal) begin
					$display("%0t operands_equal: expected %0d actual %0d", $time,
						exp_r.operands_equal, got.operands_equal);
					fails++;
				end
			end
		end
	end

	initial begin
		// op, a_num, a_den, b_num, b_den, typed, res_num, res_den, error, equal
		typedef struct {
			op_t op;
			logic [31:0] an, ad, bn, bd;
			bit typed;
			logic [31:0] rn;
			logic [30:0] rd;
			err_t err;
			bit eq;
		} row_t;
		row_t rows[18];
		trans_t tr;
		rows = '{
			'{OP_ADD, 1, 2, 1, 3, 1, 5, 6, ERR_NONE, 0},
			'{OP_SUB, 1, 2, 1, 2, 1, 0, 1, ERR_NONE, 1},
			'{OP_MUL, -2, 3, 3, 4, 1, -1, 2, ERR_NONE, 0},
			'{OP_DIV, 1, 2, -1, 4, 1, -2, 1, ERR_NONE, 0},
			'{OP_ADD, 7, 0, 1, 3, 1, 0, 0, ERR_ZERO, 0},
			'{OP_SUB, 1, 3, 5, 0, 1, 0, 0, ERR_ZERO, 0},
			'{OP_DIV, 1, 2, 0, 5, 1, 0, 0, ERR_ZERO, 0},
			'{OP_DIV, 0, 3, 0, 7, 1, 0, 0, ERR_ZERO, 1},
			'{OP_SUB, 0, 1, 3, 7, 1, -3, 7, ERR_NONE, 0},
			'{OP_ADD, 5, 7, 1, 1, 1, 12, 7, ERR_NONE, 0},
			'{OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				1, 0, 1, ERR_NONE, 1},
			'{OP_DIV, 32'h8000_0000, 32'hC000_0000, 2, 1, 1, 1, 1, ERR_NONE, 1},
			'{OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
				1, 1, 1, ERR_NONE, 1},
			'{OP_ADD, -1, -1, -1, -1, 1, 2, 1, ERR_NONE, 1},
			'{OP_DIV, 32'h4000_0000, 3, 32'hC000_0000, 3, 1, -1, 1, ERR_NONE, 0},
			'{OP_ADD, 32'h7FFF_FFFF, 1, 1, 1, 1, 0, 0, ERR_OVFL, 0},
			'{OP_SUB, 32'h8000_0001, 1, 1, 1, 1, 32'h8000_0000, 1, ERR_NONE, 0},
			'{OP_MUL, 6, 35, 14, 9, 0, 0, 0, ERR_NONE, 0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			tr.d.operation = rows[i].op;
			tr.d.a_num = rows[i].an;
			tr.d.a_den = rows[i].ad;
			tr.d.b_num = rows[i].bn;
			tr.d.b_den = rows[i].bd;
			if (rows[i].typed) begin
				tr.want.res_num = rows[i].rn;
				tr.want.res_den = rows[i].rd;
				tr.want.error_code = rows[i].err;
				tr.want.operands_equal = rows[i].eq;
			end else begin
				reduce_fraction(tr.d, tr.want);
			end
			send_q.push_back(tr);
		end
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 24 : 0;
			recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 24 : 0;
			queue_random(RandomPerPhase);
			if (ph == 0) hold_left = 3000;
			drain();
		end
		repeat (300) @(posedge clk);
		if (fails == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

### sim.f
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
tb/sv/rational_arithmetic_unit_tb.sv
